/* hdl/keyed_array_list_engine_core_macros.svh */
// Assertion macros for the list engine modules; the sequencer is the one that includes them.
`ifndef KEYED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define KEYED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH

`define KALE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define KALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define KALE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/kale_pkg.sv */
package kale_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACT_W    = 3;
  localparam int POS_W    = 6;
  localparam int KEY_W    = 32;
  localparam int ST_W     = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_DELETE  = 3'd1,
    ACT_FIND    = 3'd2,
    ACT_SORT_UP = 3'd3,
    ACT_SORT_DN = 3'd4
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_MISSING = 2'd2
  } st_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_mode_t;

  typedef struct packed {
    key_t key;
    key_t payload;
  } entry_t;

  typedef struct packed {
    act_t action;
    pos_t position;
    key_t key;
    key_t payload;
  } cmd_t;

  typedef struct packed {
    st_t  status;
    idx_t found;
    cnt_t count;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

/* hdl/kale_cmp.sv */
module kale_cmp (
  input  kale_pkg::key_t      a,
  input  kale_pkg::key_t      b,
  input  kale_pkg::cmp_mode_t mode,
  output logic                hit
);
  import kale_pkg::*;

  always_comb begin
    unique case (mode)
      CMP_EQ:  hit = (a == b);
      CMP_LT:  hit = (a < b);
      CMP_GT:  hit = (a > b);
      default: hit = 1'b0;
    endcase
  end

endmodule

/* hdl/kale_seq.sv */
`include "keyed_array_list_engine_core_macros.svh"

module kale_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  kale_pkg::cmd_t      cmd,
  input  logic                res_ready,
  output kale_pkg::seq_stat_t stat,
  output kale_pkg::res_t      res
);
  import kale_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LDI  = 7'b0000010,
    S_GETI = 7'b0000100,
    S_RD   = 7'b0001000,
    S_EX   = 7'b0010000,
    S_WR   = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);
  localparam cnt_t ONE_CNT = cnt_t'(1);
  localparam cnt_t TWO_CNT = cnt_t'(2);
  localparam idx_t ONE_IDX = idx_t'(1);

  state_t state_r, state_nxt;
  act_t   act_r, act_nxt;
  pos_t   pos_r, pos_nxt;
  key_t   key_r, key_nxt;
  key_t   pay_r, pay_nxt;
  cnt_t   cnt_r, cnt_nxt;
  idx_t   i_r, i_nxt;
  idx_t   j_r, j_nxt;
  entry_t cur_r, cur_nxt;
  st_t    st_r, st_nxt;
  idx_t   fnd_r, fnd_nxt;

  entry_t    mem [CAPACITY];
  entry_t    rd_r;
  logic      we;
  idx_t      waddr;
  idx_t      raddr;
  entry_t    wdata;

  idx_t      jm1;
  idx_t      jp1;
  idx_t      ip1;
  cmp_mode_t cmp_mode;
  key_t      cmp_b;
  logic      hit;

  assign jm1 = j_r - ONE_IDX;
  assign jp1 = j_r + ONE_IDX;
  assign ip1 = i_r + ONE_IDX;

  always_comb begin
    unique case (act_r)
      ACT_FIND:    cmp_mode = CMP_EQ;
      ACT_SORT_DN: cmp_mode = CMP_GT;
      default:     cmp_mode = CMP_LT;
    endcase
    cmp_b = (act_r == ACT_FIND) ? key_r : cur_r.key;
  end

  kale_cmp u_cmp (
    .a    (rd_r.key),
    .b    (cmp_b),
    .mode (cmp_mode),
    .hit  (hit)
  );

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cur_nxt   = cur_r;
    st_nxt    = st_r;
    fnd_nxt   = fnd_r;
    we        = 1'b0;
    waddr     = j_r;
    wdata     = cur_r;
    raddr     = j_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = cmd.action;
          pos_nxt = cmd.position;
          key_nxt = cmd.key;
          pay_nxt = cmd.payload;
          st_nxt  = ST_OK;
          fnd_nxt = '0;
          unique case (cmd.action)
            ACT_INSERT: begin
              if ((cnt_r >= CAP_CNT) || (cmd.position > cnt_r)) begin
                st_nxt    = ST_BAD;
                state_nxt = S_DONE;
              end else begin
                j_nxt     = cnt_r[IDX_W-1:0];
                state_nxt = (cmd.position == cnt_r) ? S_WR : S_RD;
              end
            end
            ACT_DELETE: begin
              if (cmd.position >= cnt_r) begin
                st_nxt    = ST_BAD;
                state_nxt = S_DONE;
              end else begin
                j_nxt = cmd.position[IDX_W-1:0];
                if ((cnt_t'(cmd.position) + ONE_CNT) >= cnt_r) begin
                  cnt_nxt   = cnt_r - ONE_CNT;
                  state_nxt = S_DONE;
                end else begin
                  state_nxt = S_RD;
                end
              end
            end
            ACT_FIND: begin
              j_nxt = '0;
              if (cnt_r == '0) begin
                st_nxt    = ST_MISSING;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            ACT_SORT_UP, ACT_SORT_DN: begin
              i_nxt     = '0;
              state_nxt = (cnt_r < TWO_CNT) ? S_DONE : S_LDI;
            end
            default: begin
              st_nxt    = ST_BAD;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LDI: begin
        raddr     = i_r;
        state_nxt = S_GETI;
      end
      S_GETI: begin
        cur_nxt   = rd_r;
        j_nxt     = ip1;
        state_nxt = S_RD;
      end
      S_RD: begin
        unique case (act_r)
          ACT_INSERT: raddr = jm1;
          ACT_DELETE: raddr = jp1;
          default:    raddr = j_r;
        endcase
        state_nxt = S_EX;
      end
      S_EX: begin
        unique case (act_r)
          ACT_INSERT: begin
            we        = 1'b1;
            waddr     = j_r;
            wdata     = rd_r;
            j_nxt     = jm1;
            state_nxt = (jm1 == pos_r[IDX_W-1:0]) ? S_WR : S_RD;
          end
          ACT_DELETE: begin
            we    = 1'b1;
            waddr = j_r;
            wdata = rd_r;
            j_nxt = jp1;
            if ((cnt_t'(jp1) + ONE_CNT) >= cnt_r) begin
              cnt_nxt   = cnt_r - ONE_CNT;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RD;
            end
          end
          ACT_FIND: begin
            if (hit) begin
              fnd_nxt   = j_r;
              st_nxt    = ST_OK;
              state_nxt = S_DONE;
            end else if ((cnt_t'(j_r) + ONE_CNT) >= cnt_r) begin
              st_nxt    = ST_MISSING;
              state_nxt = S_DONE;
            end else begin
              j_nxt     = jp1;
              state_nxt = S_RD;
            end
          end
          ACT_SORT_UP, ACT_SORT_DN: begin
            if (hit) begin
              we      = 1'b1;
              waddr   = j_r;
              wdata   = cur_r;
              cur_nxt = rd_r;
            end
            if ((cnt_t'(j_r) + ONE_CNT) < cnt_r) begin
              j_nxt     = jp1;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_WR;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_WR: begin
        we = 1'b1;
        if (act_r == ACT_INSERT) begin
          waddr     = pos_r[IDX_W-1:0];
          wdata     = '{key: key_r, payload: pay_r};
          cnt_nxt   = cnt_r + ONE_CNT;
          state_nxt = S_DONE;
        end else begin
          waddr = i_r;
          wdata = cur_r;
          if ((cnt_t'(i_r) + TWO_CNT) < cnt_r) begin
            i_nxt     = ip1;
            state_nxt = S_LDI;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    pay_r <= pay_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cur_r <= cur_nxt;
    st_r  <= st_nxt;
    fnd_r <= fnd_nxt;
  end

  assign stat.idle  = (state_r == S_IDLE);
  assign stat.done  = (state_r == S_DONE);
  assign res.status = st_r;
  assign res.found  = fnd_r;
  assign res.count  = cnt_r;

  `KALE_ASSERT_ALWAYS(a_cnt_cap, cnt_r <= CAP_CNT, "Entry count exceeds capacity.")
  `KALE_ASSERT_NXT(a_cnt_hold, (state_r == S_IDLE) && !start, $stable(cnt_r), "Count moved while idle.")
  `KALE_ASSERT_IMP(a_found_ok, (state_r == S_DONE) && (fnd_r != '0), (st_r == ST_OK) && (act_r == ACT_FIND), "Nonzero index without a successful find.")
  `KALE_ASSERT_IMP(a_wr_busy, we, (state_r != S_IDLE) && (state_r != S_DONE), "Store written outside an action.")

endmodule

/* hdl/keyed_array_list_engine_core.sv */
// Bad or unused actions finish without touching the store; insert and delete shift the
// entries between the position and the end, find scans from entry zero, and sort runs
// one pass for each position but the last, finishing at once with fewer than two entries.
// One item is in work at a time; the pace is set by the entry store, with one write
// port and one registered read port, and the one shared key comparator. A result held by
// a stalled output blocks the next input beat. Reset clears the count, not the entries.
module keyed_array_list_engine_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kale_pkg::ACT_W-1:0]  in_action,
  input  logic [kale_pkg::POS_W-1:0]  in_position,
  input  logic [kale_pkg::KEY_W-1:0]  in_key,
  input  logic [kale_pkg::KEY_W-1:0]  in_payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kale_pkg::ST_W-1:0]   out_status,
  output logic [kale_pkg::IDX_W-1:0]  out_found_index,
  output logic [kale_pkg::CNT_W-1:0]  out_entry_count
);
  import kale_pkg::*;

  cmd_t      cmd;
  res_t      res;
  seq_stat_t stat;
  logic      start;
  logic      res_ready;
  logic      out_valid_r;
  res_t      out_res_r;

  assign in_stall  = !stat.idle;
  assign start     = in_valid && !in_stall;
  assign res_ready = !out_valid_r || !out_stall;

  assign cmd.action   = act_t'(in_action);
  assign cmd.position = in_position;
  assign cmd.key      = in_key;
  assign cmd.payload  = in_payload;

  kale_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .res_ready (res_ready),
    .stat      (stat),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_found_index = out_res_r.found;
  assign out_entry_count = out_res_r.count;

endmodule
